### design/cwm_pkg.sv
// ----------------------------------------------------------------------------
// cwm_pkg: shared types and constants of the word window matcher
// Sizes of the word table, the text window and the command and register codes.
// ----------------------------------------------------------------------------
package cwm_pkg;

  localparam int MAX_WORDS    = 64;
  localparam int MAX_WORD_LEN = 32;
  localparam int MAX_TEXT     = 65536;

  localparam int SLOT_W  = $clog2(MAX_WORDS);
  localparam int ID_W    = SLOT_W + 1;
  localparam int PH_W    = $clog2(MAX_WORD_LEN);
  localparam int WC_AW   = PH_W + SLOT_W;
  localparam int TP_W    = $clog2(MAX_TEXT) + 1;
  localparam int LEN_W   = 6;
  localparam int CNT_W   = 7;
  localparam int OUT_W   = 16;
  localparam int MM_W    = 8;
  localparam int EPOCH_W = 8;

  localparam logic [ID_W-1:0] NO_ID = {ID_W{1'b1}};

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TEXT  = 2'd1;
  localparam logic [1:0] CMD_NEW   = 2'd2;

  localparam logic [1:0] REG_WORD_LEN   = 2'd0;
  localparam logic [1:0] REG_WORD_COUNT = 2'd1;

  typedef logic [MAX_WORD_LEN-1:0][7:0] cwm_letters_t;

  // Write control for the row of table cells.
  typedef struct packed {
    logic              wr;
    logic              inc;
    logic [SLOT_W-1:0] idx;
  } cwm_ctrl_t;

endpackage

### design/cwm_chan_if.sv
// ----------------------------------------------------------------------------
// cwm channel interfaces
// Valid/ready channels for the incoming command words and the result words.
// ----------------------------------------------------------------------------
interface cwm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] letter;
  modport source (output valid, output cmd, output letter, input ready);
  modport sink   (input valid, input cmd, input letter, output ready);
endinterface

interface cwm_out_if;
  logic                     valid;
  logic                     ready;
  logic [cwm_pkg::OUT_W-1:0] start_index;
  modport source (output valid, output start_index, input ready);
  modport sink   (input valid, input start_index, output ready);
endinterface

### design/concat_word_window_match.sv
// ----------------------------------------------------------------------------
// concat_word_window_match: finds windows made of every listed word
// Loads a word list into a row of table cells, then scans text letters and
// reports the start of each window that is a concatenation of the list.
// ----------------------------------------------------------------------------
// A word list is loaded one letter per word (cmd 0) into a row of 64 table
// cells; each cell holds one distinct word and how often it appears in the
// list, and all cells compare their word with the newest letters at once.
// Text letters (cmd 1) are then scanned; every letter that completes a word-
// length slice classifies that slice and updates the per-phase window counts
// and a per-phase mismatch tally, and when the tally is zero over a full
// window the start position comes out as one result word. Results appear in
// increasing order of window end. The last letter of a word also passes S_LD,
// the table compare. A text letter that completes a slice passes S_CMP,
// S_RD1, S_UP, S_RD2, S_DN and S_OUT in order: a read-modify-write of two
// window counters in the counter memory, then the result, which waits in
// S_OUT on a full output register. Letters are accepted only in S_IDLE.
// The counter memory is cleared by a pass over its 2048 entries after reset and
// after every 256th start of a new text; no word is accepted meanwhile.
// Configuration writes reset the word list and the text state.
// ----------------------------------------------------------------------------
module concat_word_window_match (
  input  logic               clk,
  input  logic               rst_n,
  cwm_in_if.sink             in_ch,
  cwm_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [6:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_LD, S_CMP, S_RD1, S_UP, S_RD2, S_DN, S_OUT
  } state_t;

  typedef struct packed {
    logic [cwm_pkg::EPOCH_W-1:0] tag;
    logic [cwm_pkg::CNT_W-1:0]   cnt;
  } wc_t;

  localparam int WC_DEPTH = cwm_pkg::MAX_WORD_LEN * cwm_pkg::MAX_WORDS;

  state_t                          state_r;
  logic [cwm_pkg::LEN_W-1:0]       len_r;
  logic [cwm_pkg::CNT_W-1:0]       cnt_r;
  logic [cwm_pkg::ID_W-1:0]        distinct_r;
  logic [cwm_pkg::PH_W-1:0]        llp_r;
  logic [cwm_pkg::ID_W-1:0]        lwp_r;
  cwm_pkg::cwm_letters_t           recent_r;
  cwm_pkg::cwm_letters_t           stage_r;
  logic [cwm_pkg::TP_W-1:0]        tp_r;
  logic [cwm_pkg::OUT_W-1:0]       s_r;
  logic [cwm_pkg::PH_W-1:0]        ph_r;
  logic [cwm_pkg::TP_W-1:0]        q_r;
  logic [cwm_pkg::SLOT_W-1:0]      qm_r;
  logic [cwm_pkg::OUT_W-1:0]       w_s_r;
  logic [cwm_pkg::PH_W-1:0]        w_ph_r;
  logic [cwm_pkg::TP_W-1:0]        w_q_r;
  logic [cwm_pkg::SLOT_W-1:0]      w_qm_r;
  logic [cwm_pkg::ID_W-1:0]        id_r;
  logic [cwm_pkg::ID_W-1:0]        old_r;
  logic [cwm_pkg::CNT_W-1:0]       need_r;
  logic [cwm_pkg::MM_W-1:0]        mm_r [cwm_pkg::MAX_WORD_LEN];
  logic [cwm_pkg::EPOCH_W-1:0]     epoch_r;
  logic                            clr_busy_r;
  logic [cwm_pkg::WC_AW-1:0]       clr_cnt_r;
  logic                            out_v_r;
  logic [cwm_pkg::OUT_W-1:0]       out_d_r;

  wc_t                             wc_mem [WC_DEPTH];
  wc_t                             wc_q;
  logic [cwm_pkg::ID_W-1:0]        hist_mem [WC_DEPTH];
  logic [cwm_pkg::ID_W-1:0]        hist_q;

  logic [cwm_pkg::LEN_W-1:0]       eff_l;
  logic [cwm_pkg::CNT_W-1:0]       eff_m;
  logic [cwm_pkg::OUT_W-1:0]       span;
  logic                            cfg_hit;
  logic                            in_acc;
  cwm_pkg::cwm_letters_t           probe;
  cwm_pkg::cwm_ctrl_t              ctrl;
  logic [cwm_pkg::SLOT_W-1:0]      need_sel;
  logic [cwm_pkg::MAX_WORDS-1:0]   hit;
  logic [cwm_pkg::ID_W-1:0]        hit_id;
  logic [cwm_pkg::CNT_W-1:0]       need_q;
  logic                            nt_go;
  logic [cwm_pkg::ID_W-1:0]        nt_dist;
  logic [cwm_pkg::ID_W-1:0]        dist_ld;
  logic [cwm_pkg::CNT_W-1:0]       prior;
  logic [cwm_pkg::CNT_W-1:0]       after;
  logic                            adj_en;
  logic [cwm_pkg::MM_W-1:0]        mm_cur;
  logic [cwm_pkg::MM_W-1:0]        mm_new;
  logic                            wc_we;
  logic [cwm_pkg::WC_AW-1:0]       wc_wa;
  wc_t                             wc_wd;
  logic [cwm_pkg::WC_AW-1:0]       wc_ra;
  logic [cwm_pkg::WC_AW-1:0]       hist_a;
  logic                            found;
  logic                            out_load;

  // Out-of-range register values are clamped to the supported range.
  assign eff_l = (len_r == '0) ? cwm_pkg::LEN_W'(1) :
                 (len_r > cwm_pkg::LEN_W'(cwm_pkg::MAX_WORD_LEN)) ?
                 cwm_pkg::LEN_W'(cwm_pkg::MAX_WORD_LEN) : len_r;
  assign eff_m = (cnt_r == '0) ? cwm_pkg::CNT_W'(1) :
                 (cnt_r > cwm_pkg::CNT_W'(cwm_pkg::MAX_WORDS)) ?
                 cwm_pkg::CNT_W'(cwm_pkg::MAX_WORDS) : cnt_r;
  assign span  = cwm_pkg::OUT_W'(eff_m - cwm_pkg::CNT_W'(1)) * cwm_pkg::OUT_W'(eff_l);

  assign cfg_hit = cfg_we && ((cfg_idx == cwm_pkg::REG_WORD_LEN) ||
                              (cfg_idx == cwm_pkg::REG_WORD_COUNT));
  assign in_ch.ready = (state_r == S_IDLE) && !clr_busy_r;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign probe = (state_r == S_LD) ? stage_r : recent_r;
  assign need_sel = (state_r == S_RD2) ? old_r[cwm_pkg::SLOT_W-1:0] :
                                         id_r[cwm_pkg::SLOT_W-1:0];

  cwm_row u_row (
    .clk      (clk),
    .probe    (probe),
    .len      (eff_l),
    .distinct (distinct_r),
    .ctrl     (ctrl),
    .need_sel (need_sel),
    .hit      (hit),
    .hit_id   (hit_id),
    .need_q   (need_q)
  );

  // Finishing a word: a repeat bumps its entry, a new word takes the next cell.
  always_comb begin
    ctrl    = '0;
    dist_ld = distinct_r;
    if (state_r == S_LD) begin
      if (hit_id != cwm_pkg::NO_ID) begin
        ctrl.inc = 1'b1;
        ctrl.idx = hit_id[cwm_pkg::SLOT_W-1:0];
      end else begin
        ctrl.wr = 1'b1;
        ctrl.idx = distinct_r[cwm_pkg::SLOT_W-1:0];
        dist_ld = distinct_r + cwm_pkg::ID_W'(1);
      end
    end
  end

  // Starting a new text, and the entry count that the tallies restart from.
  always_comb begin
    nt_go   = 1'b0;
    nt_dist = distinct_r;
    if (cfg_hit) begin
      nt_go   = 1'b1;
      nt_dist = '0;
    end else if (state_r == S_LD) begin
      nt_go   = 1'b1;
      nt_dist = dist_ld;
    end else if (in_acc) begin
      if (in_ch.cmd == cwm_pkg::CMD_NEW) begin
        nt_go = 1'b1;
      end else if ((in_ch.cmd == cwm_pkg::CMD_LOAD) && (lwp_r < eff_m) &&
                   ((cwm_pkg::LEN_W'(llp_r) + cwm_pkg::LEN_W'(1)) < eff_l)) begin
        nt_go = 1'b1;
      end
    end
  end

  // Window counter update: up for the new slice, down for the one leaving.
  always_comb begin
    prior  = (wc_q.tag == epoch_r) ? wc_q.cnt : '0;
    mm_cur = mm_r[w_ph_r];
    if (state_r == S_UP) begin
      after  = prior + cwm_pkg::CNT_W'(1);
      adj_en = id_r < distinct_r;
    end else begin
      after  = prior - cwm_pkg::CNT_W'(1);
      adj_en = (state_r == S_DN) && (w_q_r >= cwm_pkg::TP_W'(eff_m)) &&
               (old_r < distinct_r) && (prior != '0);
    end
    mm_new = mm_cur;
    if ((prior == need_r) && (after != need_r)) begin
      mm_new = mm_cur + cwm_pkg::MM_W'(1);
    end else if ((prior != need_r) && (after == need_r) && (mm_cur != '0)) begin
      mm_new = mm_cur - cwm_pkg::MM_W'(1);
    end
  end

  always_comb begin
    wc_we = 1'b0;
    wc_wa = clr_cnt_r;
    wc_wd = '{tag: epoch_r, cnt: '0};
    if (clr_busy_r) begin
      wc_we = 1'b1;
    end else if (adj_en) begin
      wc_we = 1'b1;
      wc_wa = (state_r == S_UP) ? {w_ph_r, id_r[cwm_pkg::SLOT_W-1:0]} :
                                  {w_ph_r, old_r[cwm_pkg::SLOT_W-1:0]};
      wc_wd = '{tag: epoch_r, cnt: after};
    end
    wc_ra  = (state_r == S_RD2) ? {w_ph_r, old_r[cwm_pkg::SLOT_W-1:0]} :
                                  {w_ph_r, id_r[cwm_pkg::SLOT_W-1:0]};
    hist_a = {w_ph_r, w_qm_r};
  end

  always_ff @(posedge clk) begin
    if (wc_we) wc_mem[wc_wa] <= wc_wd;
    wc_q <= wc_mem[wc_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UP) hist_mem[hist_a] <= id_r;
    hist_q <= hist_mem[hist_a];
  end

  assign found = (w_q_r + cwm_pkg::TP_W'(1) >= cwm_pkg::TP_W'(eff_m)) &&
                 (lwp_r >= eff_m) && (mm_r[w_ph_r] == '0);

  // A result is loaded when the output register is empty or being emptied.
  assign out_load = !cfg_hit && (state_r == S_OUT) && found &&
                    (!out_v_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= cwm_pkg::LEN_W'(1);
      cnt_r      <= cwm_pkg::CNT_W'(1);
      distinct_r <= '0;
      llp_r      <= '0;
      lwp_r      <= '0;
      recent_r   <= '0;
      tp_r       <= '0;
      s_r        <= '0;
      ph_r       <= '0;
      q_r        <= '0;
      qm_r       <= '0;
      for (int i = 0; i < cwm_pkg::MAX_WORD_LEN; i++) mm_r[i] <= '0;
      epoch_r    <= '0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_r <= 1'b1;
        out_d_r <= w_s_r - span;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end

      // A new text on a wrapped epoch restarts the clearing pass.
      if (nt_go && (epoch_r == {cwm_pkg::EPOCH_W{1'b1}})) begin
        clr_busy_r <= 1'b1;
        clr_cnt_r  <= '0;
      end else if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + cwm_pkg::WC_AW'(1);
        if (clr_cnt_r == {cwm_pkg::WC_AW{1'b1}}) clr_busy_r <= 1'b0;
      end

      if (cfg_hit) begin
        if (cfg_idx == cwm_pkg::REG_WORD_LEN) len_r <= cfg_data[cwm_pkg::LEN_W-1:0];
        else cnt_r <= cfg_data;
        distinct_r <= '0;
        llp_r      <= '0;
        lwp_r      <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_acc) begin
              if ((in_ch.cmd == cwm_pkg::CMD_LOAD) && (lwp_r < eff_m)) begin
                stage_r <= {in_ch.letter, stage_r[cwm_pkg::MAX_WORD_LEN-1:1]};
                if ((cwm_pkg::LEN_W'(llp_r) + cwm_pkg::LEN_W'(1)) >= eff_l) begin
                  llp_r   <= '0;
                  lwp_r   <= lwp_r + cwm_pkg::ID_W'(1);
                  state_r <= S_LD;
                end else begin
                  llp_r <= llp_r + cwm_pkg::PH_W'(1);
                end
              end else if ((in_ch.cmd == cwm_pkg::CMD_TEXT) &&
                           (tp_r < cwm_pkg::TP_W'(cwm_pkg::MAX_TEXT))) begin
                recent_r <= {in_ch.letter, recent_r[cwm_pkg::MAX_WORD_LEN-1:1]};
                tp_r     <= tp_r + cwm_pkg::TP_W'(1);
                if ((tp_r + cwm_pkg::TP_W'(1)) >= cwm_pkg::TP_W'(eff_l)) begin
                  w_s_r  <= s_r;
                  w_ph_r <= ph_r;
                  w_q_r  <= q_r;
                  w_qm_r <= qm_r;
                  s_r    <= s_r + cwm_pkg::OUT_W'(1);
                  if ((cwm_pkg::LEN_W'(ph_r) + cwm_pkg::LEN_W'(1)) == eff_l) begin
                    ph_r <= '0;
                    q_r  <= q_r + cwm_pkg::TP_W'(1);
                    if ((cwm_pkg::CNT_W'(qm_r) + cwm_pkg::CNT_W'(1)) == eff_m) begin
                      qm_r <= '0;
                    end else begin
                      qm_r <= qm_r + cwm_pkg::SLOT_W'(1);
                    end
                  end else begin
                    ph_r <= ph_r + cwm_pkg::PH_W'(1);
                  end
                  state_r <= S_CMP;
                end
              end
            end
          end
          S_LD: begin
            distinct_r <= dist_ld;
            state_r    <= S_IDLE;
          end
          S_CMP: begin
            id_r    <= hit_id;
            state_r <= S_RD1;
          end
          S_RD1: begin
            old_r   <= hist_q;
            need_r  <= need_q;
            state_r <= S_UP;
          end
          S_UP: begin
            if (adj_en) mm_r[w_ph_r] <= mm_new;
            state_r <= S_RD2;
          end
          S_RD2: begin
            need_r  <= need_q;
            state_r <= S_DN;
          end
          S_DN: begin
            if (adj_en) mm_r[w_ph_r] <= mm_new;
            state_r <= S_OUT;
          end
          S_OUT: begin
            if (!found || out_load) begin
              state_r <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end

      // A new text restarts the position counters and the tallies, and moves
      // the counter memory to a fresh epoch.
      if (nt_go) begin
        recent_r <= '0;
        tp_r     <= '0;
        s_r      <= '0;
        ph_r     <= '0;
        q_r      <= '0;
        qm_r     <= '0;
        for (int i = 0; i < cwm_pkg::MAX_WORD_LEN; i++) begin
          mm_r[i] <= cwm_pkg::MM_W'(nt_dist);
        end
        epoch_r <= epoch_r + cwm_pkg::EPOCH_W'(1);
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.start_index = out_d_r;

`ifndef ASSERT_OFF
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("more than one table entry matches");

  a_distinct_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= lwp_r)
    else $error("more distinct words than loaded words");

  a_loaded_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    lwp_r <= eff_m)
    else $error("loaded more words than the list holds");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (state_r == S_IDLE))
    else $error("text work while the counter memory is clearing");
`endif

endmodule

### design/cwm_cell.sv
// ----------------------------------------------------------------------------
// cwm_cell: one word table entry
// Holds a word and its required count and compares it with the probe letters.
// ----------------------------------------------------------------------------
module cwm_cell (
  input  logic                        clk,
  input  cwm_pkg::cwm_letters_t       probe,
  input  logic [cwm_pkg::MAX_WORD_LEN-1:0] mask,
  input  logic                        wr_en,
  input  logic                        inc_en,
  output logic                        match,
  output logic [cwm_pkg::CNT_W-1:0]   need
);

  cwm_pkg::cwm_letters_t           word_r;
  logic [cwm_pkg::CNT_W-1:0]       need_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_r <= probe;
      need_r <= cwm_pkg::CNT_W'(1);
    end else if (inc_en) begin
      need_r <= need_r + cwm_pkg::CNT_W'(1);
    end
  end

  // Only the newest word-length letters take part.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < cwm_pkg::MAX_WORD_LEN; i++) begin
      if (mask[i] && (probe[i] != word_r[i])) match = 1'b0;
    end
  end

  assign need = need_r;

endmodule

### design/cwm_row.sv
// ----------------------------------------------------------------------------
// cwm_row: the row of word table cells
// Finds the entry that equals the probe and serves required counts.
// ----------------------------------------------------------------------------
module cwm_row (
  input  logic                          clk,
  input  cwm_pkg::cwm_letters_t         probe,
  input  logic [cwm_pkg::LEN_W-1:0]     len,
  input  logic [cwm_pkg::ID_W-1:0]      distinct,
  input  cwm_pkg::cwm_ctrl_t            ctrl,
  input  logic [cwm_pkg::SLOT_W-1:0]    need_sel,
  output logic [cwm_pkg::MAX_WORDS-1:0] hit,
  output logic [cwm_pkg::ID_W-1:0]      hit_id,
  output logic [cwm_pkg::CNT_W-1:0]     need_q
);

  logic [cwm_pkg::MAX_WORD_LEN-1:0] mask;
  logic [cwm_pkg::MAX_WORDS-1:0]    match;
  logic [cwm_pkg::CNT_W-1:0]        need_arr [cwm_pkg::MAX_WORDS];
  logic [cwm_pkg::SLOT_W-1:0]       enc;

  always_comb begin
    for (int i = 0; i < cwm_pkg::MAX_WORD_LEN; i++) begin
      mask[i] = ((cwm_pkg::LEN_W+1)'(i) + (cwm_pkg::LEN_W+1)'(len)) >=
                (cwm_pkg::LEN_W+1)'(cwm_pkg::MAX_WORD_LEN);
    end
  end

  for (genvar k = 0; k < cwm_pkg::MAX_WORDS; k++) begin : g_cell
    cwm_cell u_cell (
      .clk    (clk),
      .probe  (probe),
      .mask   (mask),
      .wr_en  (ctrl.wr && (ctrl.idx == cwm_pkg::SLOT_W'(k))),
      .inc_en (ctrl.inc && (ctrl.idx == cwm_pkg::SLOT_W'(k))),
      .match  (match[k]),
      .need   (need_arr[k])
    );
    assign hit[k] = match[k] && (cwm_pkg::ID_W'(k) < distinct);
  end

  // Stored words are distinct, so at most one entry hits.
  always_comb begin
    enc = '0;
    for (int k = 0; k < cwm_pkg::MAX_WORDS; k++) begin
      if (hit[k]) enc = enc | cwm_pkg::SLOT_W'(k);
    end
  end

  assign hit_id = (|hit) ? {1'b0, enc} : cwm_pkg::NO_ID;
  assign need_q = need_arr[need_sel];

endmodule
